>>> sv/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and constants for the i2c eeprom address pointer block
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int DEF_MEM_BYTES = 3072;
  localparam int DATA_W        = 8;
  localparam int ADDR_IN_W     = 16;
  localparam int MOD_W         = ADDR_IN_W + 1;
  localparam int RED_STEPS     = 3;
  localparam int RED_CNT_W     = 2;
  localparam int PROD_W        = 2 * ADDR_IN_W + 1;

  localparam logic [1:0] MODE_START_WRITE = 2'd0;
  localparam logic [1:0] MODE_START_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE_BYTE  = 2'd2;
  localparam logic [1:0] MODE_READ_BYTE   = 2'd3;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_LOW  = 2'd1;
  localparam logic [1:0] PHASE_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_SET_PTR,
    ST_READ,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic arm;
    logic latch_hi;
    logic red_load_pair;
    logic red_load_hi;
    logic red_step;
    logic ptr_load;
    logic mem_wr;
    logic mem_rd;
  } cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       clr_last;
    logic       red_last;
  } status_t;

endpackage

>>> sv/i2cee_ctrl.sv
// ----------------------------------------------------------------------------
// i2cee_ctrl
// Controller: sequences clear, address reduction, writes and reads
// ----------------------------------------------------------------------------
module i2cee_ctrl import i2cee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] mode_i,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output logic       busy,
  output logic       result_valid_o
);

  state_e state_q, state_d;
  logic   rd_pend_q, rd_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    rd_pend_d      = rd_pend_q;
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (mode_i)
            MODE_START_WRITE: begin
              cmd_o.arm = 1'b1;
            end
            MODE_START_READ: begin
            end
            MODE_WRITE_BYTE: begin
              priority if (status_i.phase == PHASE_HIGH) begin
                cmd_o.latch_hi = 1'b1;
              end else if (status_i.phase == PHASE_LOW) begin
                cmd_o.red_load_pair = 1'b1;
                rd_pend_d           = 1'b0;
                state_d             = ST_REDUCE;
              end else begin
                cmd_o.mem_wr = 1'b1;
              end
            end
            MODE_READ_BYTE: begin
              if (status_i.phase == PHASE_LOW) begin
                cmd_o.red_load_hi = 1'b1;
                rd_pend_d         = 1'b1;
                state_d           = ST_REDUCE;
              end else begin
                state_d = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_last) begin
          state_d = ST_SET_PTR;
        end
      end
      ST_SET_PTR: begin
        cmd_o.ptr_load = 1'b1;
        state_d        = rd_pend_q ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/i2cee_dpath.sv
// ----------------------------------------------------------------------------
// i2cee_dpath
// Datapath: address phase, pointer, reciprocal modulo reducer and byte memory
// ----------------------------------------------------------------------------
module i2cee_dpath import i2cee_pkg::*; #(
  parameter int MEM_BYTES = DEF_MEM_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [DATA_W-1:0] data_byte_i,
  output status_t           status_o,
  output logic [DATA_W-1:0] read_data_o
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(MEM_BYTES - 1);
  localparam logic [MOD_W-1:0] MOD_VAL   = MOD_W'(MEM_BYTES);
  localparam logic [MOD_W-1:0] RECIP     = MOD_W'((1 << ADDR_IN_W) / MEM_BYTES);

  logic [1:0]           phase_q, phase_d;
  logic [DATA_W-1:0]    hi_q, hi_d;
  logic [AW-1:0]        ptr_q, ptr_d, ptr_inc;
  logic [AW-1:0]        clr_q;
  logic [ADDR_IN_W-1:0] rem_q, rem_d;
  logic [ADDR_IN_W-1:0] quo_q, quo_d;
  logic [PROD_W-1:0]    recip_prod, back_prod;
  logic [RED_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rdata_q;
  logic [DATA_W-1:0]    mem [MEM_BYTES];
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [DATA_W-1:0]    wdata;

  assign ptr_inc = (ptr_q == LAST_ADDR) ? '0 : ptr_q + AW'(1);

  // quotient estimate is exact or one low, so one final subtract suffices
  assign recip_prod = PROD_W'(rem_q) * PROD_W'(RECIP);
  assign back_prod  = PROD_W'(quo_q) * PROD_W'(MOD_VAL);

  always_comb begin
    phase_d = phase_q;
    hi_d    = hi_q;
    ptr_d   = ptr_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    if (cmd_i.arm) begin
      phase_d = PHASE_HIGH;
    end
    if (cmd_i.latch_hi) begin
      hi_d    = data_byte_i;
      phase_d = PHASE_LOW;
    end
    if (cmd_i.red_load_pair || cmd_i.red_load_hi) begin
      rem_d   = cmd_i.red_load_pair ? {hi_q, data_byte_i} : {{DATA_W{1'b0}}, hi_q};
      cnt_d   = '0;
      phase_d = PHASE_IDLE;
    end
    if (cmd_i.red_step) begin
      unique case (cnt_q)
        RED_CNT_W'(0): begin
          quo_d = recip_prod[ADDR_IN_W +: ADDR_IN_W];
        end
        RED_CNT_W'(1): begin
          rem_d = rem_q - back_prod[ADDR_IN_W-1:0];
        end
        default: begin
          if ({1'b0, rem_q} >= MOD_VAL) begin
            rem_d = rem_q - MOD_VAL[ADDR_IN_W-1:0];
          end
        end
      endcase
      cnt_d = cnt_q + RED_CNT_W'(1);
    end
    if (cmd_i.ptr_load) begin
      ptr_d = rem_q[AW-1:0];
    end
    if (cmd_i.mem_wr || cmd_i.mem_rd) begin
      ptr_d = ptr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_IDLE;
      hi_q    <= '0;
      ptr_q   <= '0;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign we    = cmd_i.clr_en || cmd_i.mem_wr;
  assign waddr = cmd_i.clr_en ? clr_q : ptr_q;
  assign wdata = cmd_i.clr_en ? '0 : data_byte_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[ptr_q];
    end
  end

  assign status_o.phase    = phase_q;
  assign status_o.clr_last = (clr_q == LAST_ADDR);
  assign status_o.red_last = (cnt_q == RED_CNT_W'(RED_STEPS - 1));
  assign read_data_o       = rdata_q;

endmodule

>>> sv/i2c_eeprom_address_pointer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_address_pointer
// Byte memory behind an i2c slave with a two-byte address pointer.
// Start and write events are taken in ST_IDLE; a write ending the address
// runs the 3-step reciprocal modulo reducer, then loads the pointer. A read
// registers its byte in ST_READ and strobes it in ST_OUT, after the reducer
// and pointer load when a single address byte is pending; busy meanwhile.
// After reset every memory byte is cleared to zero with busy high.
// The receiver cannot stall: each result strobe is high for one cycle.
// ----------------------------------------------------------------------------
module i2c_eeprom_address_pointer import i2cee_pkg::*; #(
  parameter int MEM_BYTES = DEF_MEM_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  logic [DATA_W-1:0] data_byte_i,
  output logic              result_valid_o,
  output logic [DATA_W-1:0] read_data_o
);

  cmd_t    cmd;
  status_t status;

  i2cee_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .mode_i         (mode_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  i2cee_dpath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (data_byte_i),
    .status_o    (status),
    .read_data_o (read_data_o)
  );

`ifndef ASSERT_OFF
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while not busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_READ_BYTE) |=> busy)
    else $error("read request did not make block busy");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ptr_load |-> (32'(u_dpath.rem_q) < 32'(MEM_BYTES)))
    else $error("reduced address out of range");
`endif

endmodule

>>> sim/i2c_eeprom_address_pointer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_eeprom_address_pointer_tb
// Drives bus events into the eeprom address pointer block: a short directed
// table of address extremes and pointer corner cases, then random write and
// read transactions under several idle patterns. Each read byte is compared
// against a behavioral copy of the memory and address pointer, or against a
// fixed expected byte in the typed directed rows.
module i2c_eeprom_address_pointer_tb;
  import i2cee_pkg::*;

  localparam int MEM_BYTES = DEF_MEM_BYTES;
  localparam int PHASE_ITEMS = 256;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] data;
    logic              typed;
    logic [DATA_W-1:0] read_byte;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        mode_i = MODE_START_READ;
  logic [DATA_W-1:0] data_byte_i = '0;
  logic              result_valid_o;
  logic [DATA_W-1:0] read_data_o;

  // behavioral copy of the block state
  logic [1:0]        model_phase = PHASE_IDLE;
  logic [DATA_W-1:0] model_hi = '0;
  int                model_ptr = 0;
  logic [DATA_W-1:0] model_mem [MEM_BYTES];

  logic [DATA_W-1:0] expected_reads [$];
  logic [DATA_W-1:0] oldest_read;
  logic [15:0]       recent_addr = '0;
  int                idle_pct = 0;
  int                requests_sent = 0;
  int                reads_checked = 0;
  int                bytes_stored = 0;
  int                addr_loads = 0;
  int                short_addr_reads = 0;
  int                mismatch_count = 0;

  i2c_eeprom_address_pointer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit apply_bus_event(input logic [1:0] m, input logic [DATA_W-1:0] d,
                                         output logic [DATA_W-1:0] rd);
    rd = '0;
    case (m)
      MODE_START_WRITE: begin
        model_phase = PHASE_HIGH;
        return 1'b0;
      end
      MODE_START_READ: return 1'b0;
      MODE_WRITE_BYTE: begin
        if (model_phase == PHASE_HIGH) begin
          model_hi = d;
          model_phase = PHASE_LOW;
        end else if (model_phase == PHASE_LOW) begin
          model_ptr = int'({model_hi, d}) % MEM_BYTES;
          model_phase = PHASE_IDLE;
          addr_loads++;
        end else begin
          model_mem[model_ptr] = d;
          model_ptr = (model_ptr + 1) % MEM_BYTES;
          bytes_stored++;
        end
        return 1'b0;
      end
      default: begin
        // single address byte before the read sets the pointer
        if (model_phase == PHASE_LOW) begin
          model_ptr = int'(model_hi) % MEM_BYTES;
          model_phase = PHASE_IDLE;
          short_addr_reads++;
        end
        rd = model_mem[model_ptr];
        model_ptr = (model_ptr + 1) % MEM_BYTES;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_request(input logic [1:0] m, input logic [DATA_W-1:0] d,
                              input logic typed = 1'b0,
                              input logic [DATA_W-1:0] typed_byte = '0);
    logic [DATA_W-1:0] predicted;
    bit                gives_read;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    mode_i = m;
    data_byte_i = d;
    do @(posedge clk_i); while (busy !== 1'b0);
    gives_read = apply_bus_event(m, d, predicted);
    if (gives_read) expected_reads.push_back(typed ? typed_byte : predicted);
    requests_sent++;
  endtask

  task automatic drain_reads();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic pick_address(output logic [DATA_W-1:0] hi, output logic [DATA_W-1:0] lo);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      {hi, lo} = recent_addr;
    end else if (r < 60) begin
      hi = 8'($urandom_range(0, 1));
      lo = 8'($urandom);
    end else if (r < 70) begin
      hi = 8'h0B;
      lo = 8'($urandom_range(240, 255));
    end else begin
      hi = 8'($urandom);
      lo = 8'($urandom);
    end
    recent_addr = {hi, lo};
  endtask

  task automatic run_bus_transaction();
    int                kind;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    kind = $urandom_range(0, 9);
    pick_address(hi, lo);
    if (kind <= 3) begin
      send_request(MODE_START_WRITE, 8'($urandom));
      send_request(MODE_WRITE_BYTE, hi);
      send_request(MODE_WRITE_BYTE, lo);
      repeat ($urandom_range(1, 8)) send_request(MODE_WRITE_BYTE, 8'($urandom));
    end else if (kind <= 6) begin
      send_request(MODE_START_WRITE, 8'($urandom));
      send_request(MODE_WRITE_BYTE, hi);
      send_request(MODE_WRITE_BYTE, lo);
      if ($urandom_range(0, 1)) send_request(MODE_START_READ, 8'($urandom));
      repeat ($urandom_range(1, 8)) send_request(MODE_READ_BYTE, 8'($urandom));
    end else if (kind == 7) begin
      // only the first address byte before reading
      send_request(MODE_START_WRITE, 8'($urandom));
      send_request(MODE_WRITE_BYTE, hi);
      if ($urandom_range(0, 1)) send_request(MODE_START_READ, 8'($urandom));
      repeat ($urandom_range(1, 4)) send_request(MODE_READ_BYTE, 8'($urandom));
    end else if (kind == 8) begin
      // read while the high byte is still pending
      send_request(MODE_START_WRITE, 8'($urandom));
      repeat ($urandom_range(1, 3)) send_request(MODE_READ_BYTE, 8'($urandom));
      send_request(MODE_WRITE_BYTE, hi);
      send_request(MODE_WRITE_BYTE, lo);
    end else begin
      repeat ($urandom_range(1, 4)) send_request(2'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (result_valid_o === 1'b1) begin
      if (expected_reads.size() == 0) begin
        $error("read_data: expected no result, got %02h", read_data_o);
        mismatch_count++;
      end else begin
        oldest_read = expected_reads.pop_front();
        reads_checked++;
        if (read_data_o !== oldest_read) begin
          $error("read_data: expected %02h, got %02h", oldest_read, read_data_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed_rows [25];
    int        idle_plan [4];
    directed_rows = '{
      '{MODE_READ_BYTE,   8'h3C, 1'b1, 8'h00},
      '{MODE_START_READ,  8'hFF, 1'b0, 8'h00},
      '{MODE_START_WRITE, 8'hC3, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'hFF, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'hFF, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'hA5, 1'b0, 8'h00},
      '{MODE_START_WRITE, 8'h00, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'h0B, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'hFF, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'h5A, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'hFF, 1'b0, 8'h00},
      '{MODE_START_WRITE, 8'h00, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'h00, 1'b0, 8'h00},
      '{MODE_READ_BYTE,   8'h00, 1'b0, 8'h00},
      '{MODE_START_WRITE, 8'h00, 1'b0, 8'h00},
      '{MODE_READ_BYTE,   8'hFF, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'h0B, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'hFF, 1'b0, 8'h00},
      '{MODE_START_READ,  8'h00, 1'b0, 8'h00},
      '{MODE_READ_BYTE,   8'h00, 1'b1, 8'h5A},
      '{MODE_READ_BYTE,   8'h00, 1'b1, 8'hFF},
      '{MODE_START_WRITE, 8'h00, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'h0C, 1'b0, 8'h00},
      '{MODE_WRITE_BYTE,  8'h00, 1'b0, 8'h00},
      '{MODE_READ_BYTE,   8'h00, 1'b1, 8'hFF}
    };
    // receiver cannot stall, so only request gaps vary; the 0 percent phases run without gaps
    idle_plan = '{0, 51, 0, 30};
    foreach (model_mem[i]) model_mem[i] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].data,
                   directed_rows[i].typed, directed_rows[i].read_byte);
    drain_reads();

    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      while (requests_sent < 25 + (p + 1) * PHASE_ITEMS) begin
        run_bus_transaction();
        if ($urandom_range(0, 99) == 0) drain_reads();
      end
      drain_reads();
    end

    repeat (30) @(posedge clk_i);
    $display("covered %0d requests: %0d bytes stored, %0d address loads, %0d reads checked",
             requests_sent, bytes_stored, addr_loads, reads_checked);
    $display("single address byte reads: %0d, idle patterns: 0/51/0/30 percent",
             short_addr_reads);
    if (mismatch_count == 0) begin
      $display("i2c_eeprom_address_pointer_tb OK");
    end else begin
      $display("i2c_eeprom_address_pointer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("i2c_eeprom_address_pointer_tb NOT OK");
    $finish;
  end

endmodule
